// ----- rtl/tchebycheff_scalarizer_macros.svh -----
// Assertion macros shared by the scalarizer RTL.
`ifndef TCHEBYCHEFF_SCALARIZER_MACROS_SVH
`define TCHEBYCHEFF_SCALARIZER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TCHEB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TCHEB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tcheb_pkg.sv -----
// Types and constants of the weighted Tchebycheff scalarizer.
`default_nettype none

package tcheb_pkg;

   // Field widths
   localparam int VALUE_W     = 32;   // signed Q16.16 inputs, unsigned result
   localparam int WEIGHT_W    = 17;   // unsigned Q1.16
   localparam int FRAC_BITS   = 16;   // fraction bits of the values (8..24)
   localparam int WEIGHT_FRAC = 16;   // fraction bits of the weight

   // Divider geometry
   localparam int Q1W   = VALUE_W + FRAC_BITS;          // normalized ratio width
   localparam int NUM_W = Q1W + WEIGHT_FRAC;            // dividend shift register
   localparam int TOP_W = NUM_W - VALUE_W;              // dividend bits above the quotient
   localparam int REM_W = (TOP_W > VALUE_W) ? TOP_W : VALUE_W;
   localparam int CNT_W = $clog2(Q1W);

   // Tiny-divisor path: multiply by 1/0.000001
   localparam logic [VALUE_W-1:0] TINY_RECIP = VALUE_W'(1000000);
   localparam longint unsigned TINY_LIMIT =
      ((64'd1 << VALUE_W) - 64'd1) / 64'd1000000;
   localparam int TINY_W = $clog2(TINY_LIMIT + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = WEIGHT_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMALIZE    = 1'b0,
      CSR_WEIGHT_FLOOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] obj_value;
      logic signed [VALUE_W-1:0] ideal_value;
      logic signed [VALUE_W-1:0] nadir_value;
      logic [WEIGHT_W-1:0]       weight;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] scalar_value;
      logic               saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/tchebycheff_scalarizer.sv -----
// Weighted Tchebycheff scalarizer: bit-serial divider, running max, result register.
// Path per element: plain weighted runs PREP, RATIO, the weight division, UPD; plain
//   tiny-weight skips the division; normalized adds the range division after PREP.
// One element at a time, accepted only in idle; the shared radix-2 restoring divider
//   (one quotient bit per cycle, 32+FRAC_BITS bits for nadir-ideal, 32 for weight) sets the pace.
// Reset (synchronous, active high): idle, no result pending, max and flag cleared,
//   normalize off, weight_floor = 1.
`default_nettype none

`include "tchebycheff_scalarizer_macros.svh"

module tchebycheff_scalarizer (
   input  wire                                    clock,
   input  wire                                    reset,
   // input element channel
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire tcheb_pkg::req_type                req_data,
   // result channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output tcheb_pkg::rsp_type                     rsp_data,
   // configuration writes
   input  wire                                    csr_we,
   input  wire [tcheb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [tcheb_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,    // waiting for an element
      ST_PREP,    // deviation magnitude, range check, load first division
      ST_DIV,     // one quotient bit per cycle
      ST_RATIO,   // tiny-weight product, or load of the weight division
      ST_UPD      // fold term into running max, emit on last
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type                          state_ff,        state_in;
   logic                               rsp_valid_ff,    rsp_valid_in;
   tcheb_pkg::rsp_type                 rsp_data_ff,     rsp_data_in;
   logic                               normalize_ff,    normalize_in;
   logic [tcheb_pkg::WEIGHT_W-1:0]     weight_floor_ff, weight_floor_in;
   logic [tcheb_pkg::VALUE_W-1:0]      run_max_ff,      run_max_in;
   logic                               sat_seen_ff,     sat_seen_in;

   // element held for the duration of its work
   logic [tcheb_pkg::VALUE_W:0]        diff_ff,  diff_in;   // obj - ideal, 33-bit signed
   logic [tcheb_pkg::VALUE_W:0]        rng_ff,   rng_in;    // nadir - ideal, 33-bit signed
   logic [tcheb_pkg::WEIGHT_W-1:0]     w_ff,     w_in;
   logic                               last_ff,  last_in;
   logic                               tiny_ff,  tiny_in;   // weight under the floor
   logic                               norm_ff,  norm_in;

   // divider
   logic [tcheb_pkg::REM_W-1:0]        rem_ff,   rem_in;
   logic [tcheb_pkg::NUM_W-1:0]        shf_ff,   shf_in;    // dividend out, quotient in
   logic [tcheb_pkg::VALUE_W-1:0]      div_ff,   div_in;
   logic [tcheb_pkg::CNT_W-1:0]        cnt_ff,   cnt_in;
   logic                               pass2_ff, pass2_in;  // 1: dividing by the weight

   logic [tcheb_pkg::Q1W-1:0]          ratio_ff, ratio_in;
   logic [tcheb_pkg::VALUE_W-1:0]      term_ff,  term_in;
   logic                               term_sat_ff, term_sat_in;

   // ---------------------------------------------------------------- datapath
   logic [tcheb_pkg::VALUE_W-1:0]      dev;
   logic                               rng_bad;
   logic [tcheb_pkg::NUM_W-1:0]        n2;
   logic [tcheb_pkg::TOP_W-1:0]        n2_top;
   logic                               wt_ovf;
   logic [tcheb_pkg::REM_W:0]          trial;
   logic                               qbit;
   logic [tcheb_pkg::REM_W-1:0]        rem_step;
   logic [tcheb_pkg::NUM_W-1:0]        shf_step;
   logic                               tiny_ovf;
   logic [tcheb_pkg::VALUE_W-1:0]      tiny_prod;
   logic [tcheb_pkg::VALUE_W-1:0]      new_max;
   logic                               upd_go;

   // |obj - ideal| always fits 32 bits unsigned
   assign dev = diff_ff[tcheb_pkg::VALUE_W]
              ? tcheb_pkg::VALUE_W'(-diff_ff)
              : diff_ff[tcheb_pkg::VALUE_W-1:0];

   assign rng_bad = rng_ff[tcheb_pkg::VALUE_W] || (rng_ff == '0);

   // Weight division: dividend ratio << WEIGHT_FRAC. The quotient leaves 32 bits
   // exactly when the part above the low 32 bits reaches the weight; a zero
   // weight always trips this, same as a divide by zero.
   assign n2     = tcheb_pkg::NUM_W'(ratio_ff) << tcheb_pkg::WEIGHT_FRAC;
   assign n2_top = n2[tcheb_pkg::NUM_W-1:tcheb_pkg::VALUE_W];
   assign wt_ovf = tcheb_pkg::REM_W'(n2_top) >= tcheb_pkg::REM_W'(w_ff);

   // restoring step: remainder stays below the divisor
   assign trial    = {rem_ff, shf_ff[tcheb_pkg::NUM_W-1]};
   assign qbit     = trial >= (tcheb_pkg::REM_W+1)'(div_ff);
   assign rem_step = qbit ? tcheb_pkg::REM_W'(trial - (tcheb_pkg::REM_W+1)'(div_ff))
                          : trial[tcheb_pkg::REM_W-1:0];
   assign shf_step = {shf_ff[tcheb_pkg::NUM_W-2:0], qbit};

   // tiny path: ratio * 10^6, only when the ratio is small enough to fit
   assign tiny_ovf  = ratio_ff > tcheb_pkg::Q1W'(tcheb_pkg::TINY_LIMIT);
   assign tiny_prod = tcheb_pkg::VALUE_W'(tcheb_pkg::VALUE_W'(ratio_ff[tcheb_pkg::TINY_W-1:0])
                                          * tcheb_pkg::TINY_RECIP);

   assign new_max = (term_ff > run_max_ff) ? term_ff : run_max_ff;
   // a last element waits here until the result register is free
   assign upd_go  = !last_ff || !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      normalize_in    = normalize_ff;
      weight_floor_in = weight_floor_ff;
      run_max_in      = run_max_ff;
      sat_seen_in     = sat_seen_ff;
      diff_in         = diff_ff;
      rng_in          = rng_ff;
      w_in            = w_ff;
      last_in         = last_ff;
      tiny_in         = tiny_ff;
      norm_in         = norm_ff;
      rem_in          = rem_ff;
      shf_in          = shf_ff;
      div_in          = div_ff;
      cnt_in          = cnt_ff;
      pass2_in        = pass2_ff;
      ratio_in        = ratio_ff;
      term_in         = term_ff;
      term_sat_in     = term_sat_ff;

      if (csr_we) begin
         unique case (csr_index)
            tcheb_pkg::CSR_NORMALIZE:    normalize_in    = csr_wdata[0];
            tcheb_pkg::CSR_WEIGHT_FLOOR: weight_floor_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               diff_in  = {req_data.obj_value[tcheb_pkg::VALUE_W-1], req_data.obj_value}
                        - {req_data.ideal_value[tcheb_pkg::VALUE_W-1], req_data.ideal_value};
               rng_in   = {req_data.nadir_value[tcheb_pkg::VALUE_W-1], req_data.nadir_value}
                        - {req_data.ideal_value[tcheb_pkg::VALUE_W-1], req_data.ideal_value};
               w_in     = req_data.weight;
               last_in  = req_data.last;
               tiny_in  = req_data.weight < weight_floor_ff;
               norm_in  = normalize_ff;
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            if (norm_ff) begin
               if (rng_bad) begin
                  term_in     = '1;
                  term_sat_in = 1'b1;
                  state_in    = ST_UPD;
               end else begin
                  // dev << FRAC_BITS, left-aligned; full Q1W-bit quotient
                  rem_in   = '0;
                  shf_in   = tcheb_pkg::NUM_W'(dev) << tcheb_pkg::TOP_W;
                  div_in   = rng_ff[tcheb_pkg::VALUE_W-1:0];
                  cnt_in   = tcheb_pkg::CNT_W'(tcheb_pkg::Q1W - 1);
                  pass2_in = 1'b0;
                  state_in = ST_DIV;
               end
            end else begin
               ratio_in = tcheb_pkg::Q1W'(dev);
               state_in = ST_RATIO;
            end
         end

         ST_RATIO: begin
            if (tiny_ff) begin
               term_sat_in = tiny_ovf;
               term_in     = tiny_ovf ? '1 : tiny_prod;
               state_in    = ST_UPD;
            end else if (wt_ovf) begin
               term_in     = '1;
               term_sat_in = 1'b1;
               state_in    = ST_UPD;
            end else begin
               rem_in   = tcheb_pkg::REM_W'(n2_top);
               shf_in   = {n2[tcheb_pkg::VALUE_W-1:0], {tcheb_pkg::TOP_W{1'b0}}};
               div_in   = tcheb_pkg::VALUE_W'(w_ff);
               cnt_in   = tcheb_pkg::CNT_W'(tcheb_pkg::VALUE_W - 1);
               pass2_in = 1'b1;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            rem_in = rem_step;
            shf_in = shf_step;
            cnt_in = cnt_ff - tcheb_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               if (pass2_ff) begin
                  term_in     = shf_step[tcheb_pkg::VALUE_W-1:0];
                  term_sat_in = 1'b0;
                  state_in    = ST_UPD;
               end else begin
                  ratio_in = shf_step[tcheb_pkg::Q1W-1:0];
                  state_in = ST_RATIO;
               end
            end
         end

         ST_UPD: begin
            if (upd_go) begin
               if (last_ff) begin
                  rsp_data_in.scalar_value = new_max;
                  rsp_data_in.saturated    = sat_seen_ff || term_sat_ff;
                  rsp_valid_in             = 1'b1;
                  run_max_in               = '0;
                  sat_seen_in              = 1'b0;
               end else begin
                  run_max_in  = new_max;
                  sat_seen_in = sat_seen_ff || term_sat_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         normalize_ff    <= 1'b0;
         weight_floor_ff <= tcheb_pkg::WEIGHT_W'(1);
         run_max_ff      <= '0;
         sat_seen_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         normalize_ff    <= normalize_in;
         weight_floor_ff <= weight_floor_in;
         run_max_ff      <= run_max_in;
         sat_seen_ff     <= sat_seen_in;
      end
      rsp_data_ff <= rsp_data_in;
      diff_ff     <= diff_in;
      rng_ff      <= rng_in;
      w_ff        <= w_in;
      last_ff     <= last_in;
      tiny_ff     <= tiny_in;
      norm_ff     <= norm_in;
      rem_ff      <= rem_in;
      shf_ff      <= shf_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      pass2_ff    <= pass2_in;
      ratio_ff    <= ratio_in;
      term_ff     <= term_in;
      term_sat_ff <= term_sat_in;
   end

   // ---------------------------------------------------------------- checks
   `TCHEB_ASSERT_NXT(a_accept_starts_work, req_valid && req_ready, state_ff == ST_PREP, "accepted element did not start")
   `TCHEB_ASSERT_IMP(a_div_rem_below_divisor, state_ff == ST_DIV, tcheb_pkg::REM_W'(div_ff) > rem_ff, "divider remainder not below divisor")
   `TCHEB_ASSERT_IMP(a_rsp_from_last, $rose(rsp_valid_ff), $past(state_ff == ST_UPD && last_ff), "result raised without a last element")
   `TCHEB_ASSERT_NXT(a_clear_after_emit, state_ff == ST_UPD && last_ff && upd_go, run_max_ff == '0 && !sat_seen_ff, "running max not cleared after a result transfer")

endmodule

`default_nettype wire

// ----- dv/tcheb_result_checker.sv -----
// Checker for the Tchebycheff scalarizer: predicts each vector result and compares it.
module tcheb_result_checker
   import tcheb_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  req_type               req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  rsp_type               rsp_data,
   input  wire                   csr_we,
   input  csr_index_type         csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned           pending_results,
   output int unsigned           mismatch_count
);

   localparam logic [63:0] TINY_SCALE = 64'd1_000_000;   // 1 / 0.000001
   localparam logic [63:0] TERM_MAX   = 64'hFFFF_FFFF;
   localparam logic [63:0] SHIFT_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> WEIGHT_FRAC;
   localparam int          REPORT_MAX = 10;

   logic                norm_mode   = 1'b0;
   logic [WEIGHT_W-1:0] floor_level = 17'd1;
   logic [VALUE_W-1:0]  vector_max  = '0;
   logic                vector_sat  = 1'b0;
   rsp_type             expected_scalars[$];

   // Weighted deviation of one element, saturated to 32 bits.
   function automatic logic [VALUE_W-1:0] weighted_term(input req_type e, output logic over);
      longint      diff;
      longint      span;
      logic [63:0] ratio;
      logic [63:0] quotient;
      over = 1'b0;
      diff = longint'($signed(e.obj_value)) - longint'($signed(e.ideal_value));
      ratio = (diff < 0) ? 64'(-diff) : 64'(diff);
      if (norm_mode) begin
         span = longint'($signed(e.nadir_value)) - longint'($signed(e.ideal_value));
         if (span <= 0) begin
            over = 1'b1;
            return '1;
         end
         ratio = (ratio << FRAC_BITS) / 64'(span);
      end
      if (e.weight < floor_level) begin
         if (ratio > TERM_MAX / TINY_SCALE) begin
            over = 1'b1;
            return '1;
         end
         quotient = ratio * TINY_SCALE;
      end else begin
         if (e.weight == '0 || ratio > SHIFT_MAX) begin
            over = 1'b1;
            return '1;
         end
         quotient = (ratio << WEIGHT_FRAC) / 64'(e.weight);
      end
      if (quotient > TERM_MAX) begin
         over = 1'b1;
         return '1;
      end
      return quotient[VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin : track
      rsp_type            seen;
      rsp_type            want;
      logic [VALUE_W-1:0] term;
      logic               over;
      if (reset) begin
         norm_mode   = 1'b0;
         floor_level = 17'd1;
         vector_max  = '0;
         vector_sat  = 1'b0;
         expected_scalars.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NORMALIZE:    norm_mode   = csr_wdata[0];
               CSR_WEIGHT_FLOOR: floor_level = csr_wdata[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         // results first: a result never comes from an element taken on the same edge
         if (rsp_valid && rsp_ready) begin
            seen = rsp_data;
            if (expected_scalars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected result transfer: scalar_value %h saturated %b",
                           seen.scalar_value, seen.saturated);
            end else begin
               want = expected_scalars.pop_front();
               if (seen.scalar_value !== want.scalar_value ||
                   seen.saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("result mismatch: scalar_value exp %h got %h, saturated exp %b got %b",
                              want.scalar_value, seen.scalar_value,
                              want.saturated, seen.saturated);
               end
            end
         end
         if (req_valid && req_ready) begin
            term = weighted_term(req_data, over);
            if (term > vector_max)
               vector_max = term;
            if (over)
               vector_sat = 1'b1;
            if (req_data.last) begin
               want.scalar_value = vector_max;
               want.saturated    = vector_sat;
               expected_scalars.push_back(want);
               vector_max = '0;
               vector_sat = 1'b0;
            end
         end
      end
      pending_results = expected_scalars.size();
   end

endmodule

// ----- dv/tb_tchebycheff_scalarizer.sv -----
// Testbench top for the Tchebycheff scalarizer: stimulus, idling, watchdog and verdict.
module tb_tchebycheff_scalarizer;
   import tcheb_pkg::*;

   localparam int RESET_CYCLES     = 2;
   localparam int QUIET_CYCLES     = 120;   // past the worst-case element latency
   localparam int LONG_HOLD_CYCLES = 600;   // receiver back-pressure stretch
   localparam int WATCHDOG_LIMIT   = 4000;  // cycles without any transfer or register write
   localparam int RANDOM_PHASES    = 9;
   localparam int PHASE_ITEMS      = 143;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_NORMALIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned pending_results;
   int unsigned mismatch_count;
   int unsigned stalled_cycles    = 0;
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   logic        long_hold_armed   = 1'b0;
   // Top-side copy of the floor register, used to write it and to aim weights right at it.
   logic [WEIGHT_W-1:0] floor_setting = 17'd1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   tchebycheff_scalarizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tcheb_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   // One element transfer. Inputs move on the falling edge; ready is looked at on the
   // rising edge, before the block updates. Valid stays high across back-to-back
   // elements, so it is never dropped and raised in the same step.
   task automatic send_element(input logic [VALUE_W-1:0] obj, ideal, nadir,
                               input logic [WEIGHT_W-1:0] wgt, input logic last_mark);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= req_type'{obj_value: obj, ideal_value: ideal, nadir_value: nadir,
                             weight: wgt, last: last_mark};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Stop offering, let every expected result arrive, then give a trailing element
   // that carries no last mark time to leave the divider.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // Receiver: random ready, plus one long hold-off while the sender keeps pushing,
   // so the block fills up and has to stall its input.
   initial begin : receiver
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_armed && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Watchdog: any transfer or register write restarts the count.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("** tchebycheff_scalarizer: FAILED **");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [VALUE_W-1:0]  obj;
      logic [VALUE_W-1:0]  ideal;
      logic [VALUE_W-1:0]  nadir;
      logic [VALUE_W-1:0]  dev;
      logic [WEIGHT_W-1:0] wgt;
      logic                last_mark;
      int unsigned         phase;
      int unsigned         n;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- Directed part, reset settings: plain mode, floor 1 ---
      // Widest deviation at weight 1.0 lands exactly on the top without saturating.
      send_element(32'h7FFF_FFFF, 32'h8000_0000, '0, 17'd65536, 1'b1);
      // Same deviation over the smallest weight overflows.
      send_element(32'h8000_0000, 32'h7FFF_FFFF, '0, 17'd1, 1'b1);
      // Zero weight falls under the floor: tiny divisor, zero deviation.
      send_element('0, '0, '0, '0, 1'b1);
      // Tiny divisor just in range, then just past it.
      send_element(32'd4294, '0, '0, '0, 1'b0);
      send_element(32'd4295, '0, '0, '0, 1'b1);
      // Three-element vector with a weight above 1.0 and a negative deviation.
      send_element(32'h0001_0000, '0, '0, 17'd131071, 1'b0);
      send_element(32'hFFFD_0000, '0, '0, 17'd65536, 1'b0);
      send_element(32'h0002_0000, '0, '0, 17'd32768, 1'b1);

      // --- Normalized mode, floor 0 ---
      drain_results();
      write_csr(CSR_NORMALIZE, CSR_DATA_W'(1));
      write_csr(CSR_WEIGHT_FLOOR, CSR_DATA_W'(0));
      floor_setting = '0;
      // Empty range, then reversed range: both saturate.
      send_element(32'd5, 32'd5, 32'd5, 17'd65536, 1'b1);
      send_element('0, 32'd100, 32'd50, 17'd65536, 1'b1);
      // Zero weight not under a zero floor acts as a division by zero.
      send_element(32'h0001_0000, '0, 32'h0002_0000, '0, 1'b1);
      // Half the range at weight 1.0, then full span over the widest range.
      send_element(32'h0000_8000, '0, 32'h0001_0000, 17'd65536, 1'b0);
      send_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 17'd131071, 1'b1);
      send_element('0, 32'h8000_0000, 32'h7FFF_FFFF, 17'd65536, 1'b1);

      // --- Plain mode, floor above 1.0 ---
      drain_results();
      write_csr(CSR_NORMALIZE, CSR_DATA_W'(0));
      write_csr(CSR_WEIGHT_FLOOR, 17'd131071);
      floor_setting = 17'd131071;
      send_element(32'd100, '0, '0, 17'd131070, 1'b1);   // just under the floor
      send_element(32'd1, '0, '0, 17'd131071, 1'b1);     // equal to the floor: divides

      // --- Random part: several register settings, idling schedule per phase ---
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0, 7:    floor_setting = 17'd1;
            1, 8:    floor_setting = 17'd65536;
            2, 5:    floor_setting = '0;
            3:       floor_setting = 17'd131071;
            default: floor_setting = WEIGHT_W'($urandom_range(131071));
         endcase
         write_csr(CSR_NORMALIZE, CSR_DATA_W'(phase % 2));
         write_csr(CSR_WEIGHT_FLOOR, floor_setting);
         // sender idles lightly first, then the receiver does, then neither
         sender_idle_pct   <= (phase < 3) ? 7 : (phase < 6) ? 75 : 0;
         receiver_idle_pct <= (phase < 3) ? 75 : (phase < 6) ? 7 : 0;
         if (phase == 6)
            long_hold_armed <= 1'b1;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            ideal = $urandom;
            // Mostly deviations of every magnitude around the ideal point,
            // some unrelated points.
            if ($urandom_range(9) < 2) begin
               obj = $urandom;
            end else begin
               dev = $urandom >> $urandom_range(31);
               obj = $urandom_range(1) ? ideal + dev : ideal - dev;
            end
            // Mostly a positive range of any size; some empty, reversed or wrapped.
            case ($urandom_range(9))
               0:       nadir = $urandom;
               1:       nadir = ideal - ($urandom >> $urandom_range(31));
               default: nadir = ideal + 1 + ($urandom >> $urandom_range(31));
            endcase
            case ($urandom_range(7))
               0:       wgt = '0;
               1:       wgt = 17'd65536;
               2:       wgt = WEIGHT_W'(floor_setting + $urandom_range(2) - 1); // straddle
               default: wgt = WEIGHT_W'($urandom_range(131071));
            endcase
            last_mark = ($urandom_range(2) == 0);
            send_element(obj, ideal, nadir, wgt, last_mark);
         end
      end

      drain_results();
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("** tchebycheff_scalarizer: PASSED **");
      end else begin
         $display("** tchebycheff_scalarizer: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcheb_pkg.sv
rtl/tchebycheff_scalarizer.sv
dv/tcheb_result_checker.sv
dv/tb_tchebycheff_scalarizer.sv
